// ===== hdl/ibm2ieee_pkg.sv =====
// Package for the IBM hex float to IEEE single converter.
// Shared stage payload types and constants; no dependencies.
package ibm2ieee_pkg;

  localparam int unsigned FracW = 24;
  localparam int unsigned ExpW  = 7;
  localparam int unsigned BiasW = 10;   // signed biased exponent range
  localparam int unsigned ShW   = 5;    // subnormal shift, low bits of the full shift
  localparam logic [31:0] IeeeInf = 32'h7f80_0000;

  // Stage 1 -> 2: normalized significand and biased exponent
  typedef struct packed {
    logic                    sign;
    logic                    zero;
    logic [FracW-1:0]        mant;
    logic signed [BiasW-1:0] biased;
    logic                    last;
  } norm_t;

  // Stage 2 -> 3: classified, shifted significand
  typedef struct packed {
    logic             sign;
    logic             zero;
    logic             ovf;
    logic             tiny;
    logic             lost_all;
    logic [7:0]       expo;
    logic [FracW-1:0] q;      // significand after right shift
    logic [FracW-1:0] rem;    // shifted-out bits, left aligned
    logic             last;
  } cls_t;

  // Stage 3 -> output
  typedef struct packed {
    logic [31:0] word;
    logic        ovf;
    logic        unf;
    logic        last;
  } res_t;

endpackage

// ===== hdl/ibm2ieee_norm.sv =====
// Stage 1: leading-zero count and normalize of the IBM fraction.
// Uses ibm2ieee_pkg.
module ibm2ieee_norm (
  input  logic [31:0]              ibm_word,
  input  logic                     last_in,
  output ibm2ieee_pkg::norm_t      norm
);
  logic [ibm2ieee_pkg::FracW-1:0] frac;
  logic [4:0]                     lz;

  assign frac = ibm_word[23:0];

  // priority encoder for the leading one
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (frac[i]) lz = 5'(23 - i);
    end
  end

  // biased = p + 4*expo - 153, p = 23 - lz
  always_comb begin
    norm.sign   = ibm_word[31];
    norm.zero   = (frac == '0);
    norm.mant   = frac << lz;
    norm.biased = $signed({3'b000, ibm_word[30:24]}) * 10'sd4 - $signed({5'd0, lz})
                  - 10'sd130;
    norm.last   = last_in;
  end
endmodule

// ===== hdl/ibm2ieee_class.sv =====
// Stage 2: range classification and subnormal right shift.
// Uses ibm2ieee_pkg.
module ibm2ieee_class (
  input  ibm2ieee_pkg::norm_t norm,
  output ibm2ieee_pkg::cls_t  cls
);
  logic [ibm2ieee_pkg::BiasW-1:0] s_full;
  logic [ibm2ieee_pkg::ShW-1:0]   s;
  logic [2*ibm2ieee_pkg::FracW-1:0] wide;

  assign s_full = 10'(10'sd1 - norm.biased);
  // shift only for tiny results; normal results pass the significand through
  assign s      = (norm.biased < 10'sd1) ? s_full[4:0] : '0;
  assign wide   = {norm.mant, 24'd0} >> s;

  always_comb begin
    cls.sign     = norm.sign;
    cls.zero     = norm.zero;
    cls.ovf      = norm.biased > 10'sd254;
    cls.tiny     = norm.biased < 10'sd1;
    // shift of 25 or more drops everything
    cls.lost_all = cls.tiny && (s_full > 10'd24);
    cls.expo     = norm.biased[7:0];
    cls.q        = wide[47:24];
    cls.rem      = wide[23:0];
    cls.last     = norm.last;
  end
endmodule

// ===== hdl/ibm2ieee_round.sv =====
// Stage 3: nearest-even rounding and result packing.
// Uses ibm2ieee_pkg.
module ibm2ieee_round (
  input  ibm2ieee_pkg::cls_t cls,
  output ibm2ieee_pkg::res_t res
);
  logic half, sticky, up;
  logic [23:0] qr;

  assign half   = cls.rem[23];
  assign sticky = |cls.rem[22:0];
  // for a shift of 25, only the leading one sits below half: rounds to 0
  assign up     = !cls.lost_all && half && (sticky || cls.q[0]);
  assign qr     = cls.lost_all ? 24'd0 : cls.q + 24'(up);

  always_comb begin
    res.word = {cls.sign, 31'd0};
    res.ovf  = 1'b0;
    res.unf  = 1'b0;
    res.last = cls.last;
    if (cls.zero) begin
      res.word = {cls.sign, 31'd0};
    end else if (cls.ovf) begin
      res.word = {cls.sign, 31'd0} | ibm2ieee_pkg::IeeeInf;
      res.ovf  = 1'b1;
    end else if (cls.tiny) begin
      res.word = {cls.sign, 7'd0, qr};
      res.unf  = cls.lost_all || (cls.rem != '0);
    end else begin
      res.word = {cls.sign, cls.expo, cls.q[22:0]};
    end
  end
endmodule

// ===== hdl/ibm_float_to_ieee_single.sv =====
// IBM hex float to IEEE-754 single converter, three-stage pipeline.
// An accepted word passes through the norm, class and round stage registers in turn.
// Throughput: one word per cycle; a stall holds every stage in place.
// Reset (rst, synchronous) clears the stage valid bits only.
// Depends on ibm2ieee_pkg and the three stage modules.
module ibm_float_to_ieee_single (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] ibm_word
  input  logic        s_tlast,   // last_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] ieee_word
  output logic [1:0]  m_tuser,   // [0] overflowed, [1] underflowed
  output logic        m_tlast    // last_out
);
  ibm2ieee_pkg::norm_t n_c, n_r;
  ibm2ieee_pkg::cls_t  c_c, c_r;
  ibm2ieee_pkg::res_t  r_c, r_r;
  logic v1, v2, v3;
  logic adv;

  // whole pipe moves when output is free
  assign adv      = !v3 || m_tready;
  assign s_tready = adv;

  ibm2ieee_norm  u_norm  (.ibm_word(s_tdata), .last_in(s_tlast), .norm(n_c));
  ibm2ieee_class u_class (.norm(n_r), .cls(c_c));
  ibm2ieee_round u_round (.cls(c_r), .res(r_c));

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid; v2 <= v1; v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      n_r <= n_c; c_r <= c_c; r_r <= r_c;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = r_r.word;
  assign m_tuser  = {r_r.unf, r_r.ovf};
  assign m_tlast  = r_r.last;
endmodule

// ===== hdl/ibm2ieee_checker.sv =====
// Port-level checker for ibm_float_to_ieee_single, bound to the top level.
// No package dependency.
module ibm2ieee_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  // overflow always gives infinity
  a_ovf_inf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[30:0] == 31'h7f80_0000)
    else $error("overflow without infinity");
  // flags exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("both flags set");
  // underflow result is below normal range or smallest normal
  a_unf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[30:23] <= 8'd1)
    else $error("underflow with large exponent");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  // ready whenever output is idle
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("not ready while empty");
endmodule

bind ibm_float_to_ieee_single ibm2ieee_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== test/ibm_float_to_ieee_single_chk.sv =====
// Checker for the IBM hex float to IEEE single converter: watches both streams,
// predicts each converted word and compares. Depends on nothing but the ports.
module ibm_float_to_ieee_single_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] word;
    logic        ovf;
    logic        unf;
    logic        last;
  } conv_t;

  conv_t conv_q[$];

  // integer conversion of one IBM word
  function automatic conv_t convert(logic [31:0] ibm, logic lst);
    conv_t r;
    logic [23:0] frac;
    logic [23:0] sig;
    logic [23:0] qv;
    logic [23:0] rv;
    logic [24:0] half;
    int p;
    int bexp;
    int sh;
    frac = ibm[23:0];
    r.word = {ibm[31], 31'd0};
    r.ovf = 1'b0;
    r.unf = 1'b0;
    r.last = lst;
    if (frac != 0) begin
      p = 0;
      for (int i = 0; i < 24; i++) if (frac[i]) p = i;
      sig = frac << (23 - p);
      bexp = p + 4 * int'(ibm[30:24]) - 153;
      if (bexp > 254) begin
        r.word = {ibm[31], 31'h7f80_0000};
        r.ovf = 1'b1;
      end else if (bexp >= 1) begin
        r.word = {ibm[31], bexp[7:0], sig[22:0]};
      end else begin
        sh = 1 - bexp;
        if (sh >= 26) begin
          r.unf = 1'b1;
        end else begin
          qv = sig >> sh;
          rv = sig & ((24'd1 << sh) - 24'd1);
          half = 25'd1 << (sh - 1);
          if ({1'b0, rv} > half || ({1'b0, rv} == half && qv[0])) qv = qv + 24'd1;
          r.word = {ibm[31], 7'd0, qv};
          r.unf = (rv != 0);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    conv_t e;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) conv_q.push_back(convert(s_tdata, s_tlast));
      if (m_tvalid && m_tready) begin
        if (conv_q.size() == 0) begin
          if (errors < 10) $display("unexpected transfer: %h", m_tdata);
          errors <= errors + 1;
        end else begin
          e = conv_q.pop_front();
          if (m_tdata !== e.word || m_tuser !== {e.unf, e.ovf} || m_tlast !== e.last) begin
            if (errors < 10)
              $display("mismatch: exp %h ovf %b unf %b last %b, got %h tuser %b last %b",
                       e.word, e.ovf, e.unf, e.last, m_tdata, m_tuser, m_tlast);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= conv_q.size();
  end

endmodule

// ===== test/ibm_float_to_ieee_single_tb.sv =====
// Testbench top for the IBM hex float to IEEE single converter: drives
// directed and random words with random gaps. Depends on the checker module.
module ibm_float_to_ieee_single_tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          sent_all;
  bit          done;

  ibm_float_to_ieee_single uut (.*);
  ibm_float_to_ieee_single_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random word weighted toward the interesting exponent bands
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int k;
    w = $urandom;
    k = $urandom_range(0, 9);
    case (k)
      0: w[30:24] = 7'($urandom_range(0, 6));        // deep underflow
      1, 2: w[30:24] = 7'($urandom_range(20, 29));   // subnormal boundary
      3: w[30:24] = 7'($urandom_range(94, 127));     // overflow boundary
      4: w[23:0] = w[23:0] >> $urandom_range(0, 23);
      5: w[23:0] = $urandom_range(0, 1) ? 24'd0 : w[23:0] & 24'h00000f;
      default: ;
    endcase
    return w;
  endfunction

  logic [31:0] directed[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7f00_0000, 32'h4110_0000, 32'hc276_a000,
    32'h7fff_ffff, 32'hffff_ffff, 32'h6010_0000, 32'h60ff_ffff, 32'h6100_0001,
    32'h0000_0001, 32'h00ff_ffff, 32'h8010_0000, 32'h2110_0000, 32'h2100_0001,
    32'h21ff_ffff, 32'h20ff_ffff, 32'h1f80_0000, 32'h1fc0_0000, 32'h1f40_0000,
    32'h1e80_0001, 32'h5fff_ffff, 32'h0a55_aaaa
  };

  // transfer one word, held until accepted; valid drops only across a gap
  task automatic send(logic [31:0] w, logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send(directed[i], i[0]);
    for (int i = 0; i < 1300; i++) send(rand_word(), $urandom_range(0, 7) == 0);
    s_tvalid <= 1'b0;
    sent_all = 1'b1;
  end

  // receiver: random stalls, one long hold-off early on
  initial begin
    int g;
    @(negedge rst);
    repeat (60) @(posedge clk);
    m_tready <= 1'b0;
    repeat (40) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 1) ? 1 : $urandom_range(1, 20)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transfer, and final verdict
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > 2000) begin
      done = 1'b1;
      $display("ibm_float_to_ieee_single_tb NOT OK");
      $finish;
    end
  end

  initial begin
    wait (sent_all);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (!done) begin
      done = 1'b1;
      if (errors == 0 && pending == 0) $display("ibm_float_to_ieee_single_tb OK");
      else $display("ibm_float_to_ieee_single_tb NOT OK");
      $finish;
    end
  end

endmodule
